### rtl/bsp_point_leaf_locator_assert.svh
// Assertion macros for the BSP point leaf locator checker.
// Used by the bound port checker; no other dependencies.
`ifndef BSP_POINT_LEAF_LOCATOR_ASSERT_SVH
`define BSP_POINT_LEAF_LOCATOR_ASSERT_SVH

// Clocked assertion, ignored while reset is high
`define BSPL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles
`define BSPL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bspl_pkg.sv
// Shared types and constants for the BSP point leaf locator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bspl_pkg;

  // Fixed field widths
  localparam int WORD_W   = 32;
  localparam int LINK_W   = 16;
  localparam int LEAF_W   = 15;
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int LEAF_BIT = 15;
  localparam int HALF_W   = 16;
  localparam int PROD_W   = WORD_W + HALF_W;

  // Sign bit of a 16.16 word
  localparam logic [WORD_W-1:0] SIGN_MASK = 32'h8000_0000;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One node entry as stored in the table
  typedef struct packed {
    logic [WORD_W-1:0] origin_x;
    logic [WORD_W-1:0] origin_y;
    logic [WORD_W-1:0] dir_x;
    logic [WORD_W-1:0] dir_y;
    logic [WORD_W-1:0] links;   // back child high half, front child low half
  } node_t;

  // Classified command passed from the front to the back.
  // A query carries its point in node.origin_x / node.origin_y.
  typedef struct packed {
    logic               is_query;
    logic               wr_ok;      // write index inside the table
    logic               empty;      // query against an empty table
    logic [INDEX_W-1:0] index;
    logic [LINK_W-1:0]  count;      // effective node count
    node_t              node;
  } cmd_t;

endpackage

### rtl/bspl_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Depends on bspl_pkg; feeds bspl_queue.
`timescale 1ns / 1ps

module bspl_front #(
  parameter int MAX_NODES = 4096
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [bspl_pkg::INDEX_W-1:0]  node_index,
  input  logic signed [31:0]            part_x,
  input  logic signed [31:0]            part_y,
  input  logic signed [31:0]            part_dx,
  input  logic signed [31:0]            part_dy,
  input  logic [15:0]                   front_child,
  input  logic [15:0]                   back_child,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic [bspl_pkg::COUNT_W-1:0]  node_count,
  input  logic                          q_full,
  output logic                          q_push,
  output bspl_pkg::cmd_t                q_wdata
);
  import bspl_pkg::*;

  logic [LINK_W-1:0] count_ext;
  logic [LINK_W-1:0] eff_count;

  // Clamp the node count to the table size
  assign count_ext = {{(LINK_W-COUNT_W){1'b0}}, node_count};
  assign eff_count = (32'(count_ext) > 32'(MAX_NODES)) ? LINK_W'(MAX_NODES) : count_ext;

  // Hold the source while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Build the command; a query reuses the origin slots for its point
  always_comb begin
    q_wdata          = '0;
    q_wdata.is_query = (action == ACT_QUERY);
    q_wdata.wr_ok    = (32'(node_index) < 32'(MAX_NODES));
    q_wdata.empty    = (eff_count == '0);
    q_wdata.index    = node_index;
    q_wdata.count    = eff_count;
    if (action == ACT_QUERY) begin
      q_wdata.node.origin_x = point_x;
      q_wdata.node.origin_y = point_y;
    end else begin
      q_wdata.node.origin_x = part_x;
      q_wdata.node.origin_y = part_y;
      q_wdata.node.dir_x    = part_dx;
      q_wdata.node.dir_y    = part_dy;
      q_wdata.node.links    = {back_child, front_child};
    end
  end

endmodule

### rtl/bspl_queue.sv
// Short command queue between the front end and the walker.
// Depends on bspl_pkg for the command type and depth.
`timescale 1ns / 1ps

module bspl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bspl_pkg::cmd_t wdata,
  input  logic           pop,
  output bspl_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);
  import bspl_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;

  assign full  = (fill == (Q_AW+1)'(Q_DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/bspl_walker.sv
// Back end: node table, tree walk and output register.
// Depends on bspl_pkg; takes commands from bspl_queue.
`timescale 1ns / 1ps

module bspl_walker #(
  parameter int MAX_NODES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  bspl_pkg::cmd_t              q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bspl_pkg::LEAF_W-1:0] leaf_index,
  output logic                        walk_aborted
);
  import bspl_pkg::*;

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_MUL,
    S_DECIDE,
    S_RESULT
  } state_t;

  state_t state;

  // Node table
  node_t mem [MAX_NODES];
  node_t nd;

  // Walk context
  logic [LINK_W-1:0]        cur;
  logic [LINK_W-1:0]        steps;
  logic [LINK_W-1:0]        count;
  logic [WORD_W-1:0]        px;
  logic [WORD_W-1:0]        py;
  logic [LEAF_W-1:0]        res_leaf;
  logic                     res_abort;

  // Side test pipeline
  logic                     side_q;
  logic                     need_mul;
  logic signed [WORD_W-1:0] dx_q;
  logic signed [WORD_W-1:0] dy_q;
  logic signed [HALF_W-1:0] a_q;
  logic signed [HALF_W-1:0] b_q;
  logic signed [PROD_W-1:0] left_prod;
  logic signed [PROD_W-1:0] right_prod;

  logic                     mem_we;
  logic                     rd_en;
  logic                     chk_leaf;
  logic                     chk_stop;
  logic                     out_free;

  logic [WORD_W-1:0]        dx_c;
  logic [WORD_W-1:0]        dy_c;
  logic                     side_c;
  logic                     need_mul_c;
  logic                     side_final;

  // Pop one command whenever the walker is idle
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign mem_we   = q_pop && !q_rdata.is_query && q_rdata.wr_ok;
  assign chk_leaf = cur[LEAF_BIT];
  assign chk_stop = (cur >= count) || (steps >= count);
  assign rd_en    = (state == S_CHECK) && !chk_leaf && !chk_stop;
  assign out_free = !out_valid || !out_stall;

  // Write port of the node table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[NW'(q_rdata.index)] <= q_rdata.node;
    end
  end

  // Registered read port of the node table
  always_ff @(posedge clk) begin
    if (rd_en) begin
      nd <= mem[cur[NW-1:0]];
    end
  end

  // Side test, first step: direct compares and the sign shortcut
  always_comb begin
    dx_c       = px - nd.origin_x;
    dy_c       = py - nd.origin_y;
    need_mul_c = 1'b0;
    if (nd.dir_x == '0) begin
      if ($signed(px) <= $signed(nd.origin_x)) begin
        side_c = ($signed(nd.dir_y) > 0);
      end else begin
        side_c = nd.dir_y[WORD_W-1];
      end
    end else if (nd.dir_y == '0) begin
      if ($signed(py) <= $signed(nd.origin_y)) begin
        side_c = nd.dir_x[WORD_W-1];
      end else begin
        side_c = ($signed(nd.dir_x) > 0);
      end
    end else if (((nd.dir_y ^ nd.dir_x ^ dx_c ^ dy_c) & SIGN_MASK) != '0) begin
      side_c = ((nd.dir_y ^ dx_c) & SIGN_MASK) != '0;
    end else begin
      side_c     = 1'b0;
      need_mul_c = 1'b1;
    end
  end

  // Final side: product compare after the 16-bit shift, right < left is front
  assign side_final = need_mul
                    ? !($signed(right_prod[PROD_W-1:HALF_W]) <
                        $signed(left_prod[PROD_W-1:HALF_W]))
                    : side_q;

  // Walk sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop && q_rdata.is_query) begin
            px    <= q_rdata.node.origin_x;
            py    <= q_rdata.node.origin_y;
            count <= q_rdata.count;
            steps <= '0;
            cur   <= q_rdata.count - 1'b1;
            if (q_rdata.empty) begin
              res_leaf  <= '0;
              res_abort <= 1'b0;
              state     <= S_RESULT;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          priority if (chk_leaf) begin
            res_leaf  <= cur[LEAF_W-1:0];
            res_abort <= 1'b0;
            state     <= S_RESULT;
          end else if (chk_stop) begin
            res_leaf  <= '0;
            res_abort <= 1'b1;
            state     <= S_RESULT;
          end else begin
            steps <= steps + 1'b1;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          side_q   <= side_c;
          need_mul <= need_mul_c;
          dx_q     <= dx_c;
          dy_q     <= dy_c;
          a_q      <= nd.dir_y[WORD_W-1:HALF_W];
          b_q      <= nd.dir_x[WORD_W-1:HALF_W];
          state    <= S_MUL;
        end
        S_MUL: begin
          left_prod  <= a_q * dx_q;
          right_prod <= dy_q * b_q;
          state      <= S_DECIDE;
        end
        S_DECIDE: begin
          cur   <= side_final ? nd.links[WORD_W-1:LINK_W] : nd.links[LINK_W-1:0];
          state <= S_CHECK;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            leaf_index   <= res_leaf;
            walk_aborted <= res_abort;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/bsp_point_leaf_locator.sv
// Query: each node of the walk passes through the check with its table read, then
// the side test, the product multiply and the decide state, and the walker takes
// one query at a time, taking the next only after the last result is registered.
// Node writes drain from the queue at one per cycle while the walker is idle.
// Reset (synchronous, rst high) clears node_count, the queue and the output valid;
// the node table holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps

module bsp_point_leaf_locator #(
  parameter int MAX_NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bspl_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [bspl_pkg::INDEX_W-1:0]  node_index,
  input  logic signed [31:0]            part_x,
  input  logic signed [31:0]            part_y,
  input  logic signed [31:0]            part_dx,
  input  logic signed [31:0]            part_dy,
  input  logic [15:0]                   front_child,
  input  logic [15:0]                   back_child,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bspl_pkg::LEAF_W-1:0]   leaf_index,
  output logic                          walk_aborted
);
  import bspl_pkg::*;

  logic [COUNT_W-1:0] node_count;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  cmd_t               q_wdata;
  cmd_t               q_rdata;

  // Node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  bspl_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .node_index  (node_index),
    .part_x      (part_x),
    .part_y      (part_y),
    .part_dx     (part_dx),
    .part_dy     (part_dy),
    .front_child (front_child),
    .back_child  (back_child),
    .point_x     (point_x),
    .point_y     (point_y),
    .node_count  (node_count),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  bspl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  bspl_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .leaf_index   (leaf_index),
    .walk_aborted (walk_aborted)
  );

endmodule

### rtl/bspl_checker.sv
// Port-level checker for the BSP point leaf locator, bound to the top level.
// Depends on bspl_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bsp_point_leaf_locator_assert.svh"

module bspl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bspl_pkg::LEAF_W-1:0]  leaf_index,
  input logic                         walk_aborted
);
  import bspl_pkg::*;

  logic              out_held;
  logic              abort_out;
  logic [LEAF_W:0]   out_word;

  // Short names for the result port conditions
  assign out_held  = out_valid && out_stall;
  assign abort_out = out_valid && walk_aborted;
  assign out_word  = {walk_aborted, leaf_index};

  // A stalled result stays offered
  `BSPL_ASSERT(a_out_hold, clk, rst, out_held |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `BSPL_ASSERT(a_out_stable, clk, rst, out_held |=> $stable(out_word), "stalled result changed")

  // An aborted walk reports leaf zero
  `BSPL_ASSERT(a_abort_zero, clk, rst, abort_out |-> leaf_index == '0, "abort with nonzero leaf")

  // Reset leaves no result pending and the input open
  `BSPL_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind bsp_point_leaf_locator bspl_checker u_bspl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .leaf_index   (leaf_index),
  .walk_aborted (walk_aborted)
);
